>>> rtl/ascii_hex_can_frame_parser_unit_defines.svh
// Assertion macros shared by the frame parser RTL.
`ifndef ASCII_HEX_CAN_FRAME_PARSER_UNIT_DEFINES_SVH
`define ASCII_HEX_CAN_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define AHCFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define AHCFP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AHCFP_ASSERT(lbl, prop, msg)
`define AHCFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/ahcfp_pkg.sv
// Types, character codes and helpers for the ASCII hex CAN frame parser.
`default_nettype none
package ahcfp_pkg;

	localparam int unsigned MAX_BYTES     = 8;
	localparam int unsigned PAYLOAD_BYTES = 8;
	localparam int unsigned ID_W          = 32;
	localparam int unsigned IDX_CNT_W     = 4;

	localparam logic [ID_W-1:0] RESET_ID = 32'h0000_0050;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] HEX_A_VAL = 8'd10;

	typedef struct packed {
		logic [ID_W-1:0]                frame_id;
		logic                           is_extended;
		logic [MAX_BYTES-1:0][7:0]      data;
	} result_t;

	// Full 8-bit value, not clamped to a single hex digit.
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		if (c inside {[CH_0:CH_9]}) begin
			v = c - CH_0;
		end else begin
			v = c - CH_A + HEX_A_VAL;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ascii_hex_can_frame_parser_unit.sv
// Top level of the ASCII hex CAN frame parser.
// Takes one character per beat and can accept a beat every clock cycle. A frame
// ('S' or 'E', hex id, space, eight space/CR/LF separated hex bytes) is registered
// from the beat carrying its final separator. The output side is a result register
// backed by a one-entry skid stage; in_ready drops only while the skid stage holds
// a result that the downstream side has not yet taken.
`default_nettype none
module ascii_hex_can_frame_parser_unit #(
	parameter int unsigned PAYLOAD_BYTES = ahcfp_pkg::PAYLOAD_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      frame_id,
	output logic             is_extended,
	output logic [7:0]       byte_0,
	output logic [7:0]       byte_1,
	output logic [7:0]       byte_2,
	output logic [7:0]       byte_3,
	output logic [7:0]       byte_4,
	output logic [7:0]       byte_5,
	output logic [7:0]       byte_6,
	output logic [7:0]       byte_7
);
	import ahcfp_pkg::*;

	logic    accept;
	logic    emit;
	result_t res;
	result_t out_res;

	assign accept = in_valid && in_ready;

	ahcfp_parser #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.char_in (char_in),
		.emit    (emit),
		.result  (res)
	);

	ahcfp_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && emit),
		.push_data  (res),
		.can_accept (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_res)
	);

	assign frame_id    = out_res.frame_id;
	assign is_extended = out_res.is_extended;
	assign byte_0      = out_res.data[0];
	assign byte_1      = out_res.data[1];
	assign byte_2      = out_res.data[2];
	assign byte_3      = out_res.data[3];
	assign byte_4      = out_res.data[4];
	assign byte_5      = out_res.data[5];
	assign byte_6      = out_res.data[6];
	assign byte_7      = out_res.data[7];

endmodule
`default_nettype wire

>>> rtl/ahcfp_parser.sv
// Per-character parse state: identifier, flags, byte index and payload bytes.
`default_nettype none
`include "ascii_hex_can_frame_parser_unit_defines.svh"
module ahcfp_parser #(
	parameter int unsigned PAYLOAD_BYTES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         char_in,
	output logic                    emit,
	output ahcfp_pkg::result_t      result
);
	import ahcfp_pkg::*;

	localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	logic [ID_W-1:0]      id_q;
	logic                 ext_q;
	logic                 id_done_q;
	logic [IDX_CNT_W-1:0] byte_index_q;
	logic [7:0]           store_q [PAYLOAD_BYTES];

	logic                 is_start;
	logic                 is_sep;
	logic [7:0]           dv;
	logic [IDX_CNT_W-1:0] idx_nxt;
	logic                 last_byte;
	logic [IDX_W-1:0]     cur_idx;
	logic [IDX_W-1:0]     nxt_idx;

	assign is_start  = (char_in == CH_S) || (char_in == CH_E);
	assign is_sep    = (char_in == CH_SPACE) || (char_in == CH_CR) || (char_in == CH_LF);
	assign dv        = digit_value(char_in);
	assign idx_nxt   = byte_index_q + IDX_CNT_W'(1);
	assign last_byte = idx_nxt >= IDX_CNT_W'(PAYLOAD_BYTES);
	// byte_index stays below PAYLOAD_BYTES, so the low bits address the store
	assign cur_idx   = byte_index_q[IDX_W-1:0];
	assign nxt_idx   = idx_nxt[IDX_W-1:0];

	assign emit = !is_start && id_done_q && is_sep && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q         <= RESET_ID;
			ext_q        <= 1'b0;
			id_done_q    <= 1'b0;
			byte_index_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				ext_q        <= (char_in == CH_E);
				byte_index_q <= '0;
				id_q         <= '0;
				id_done_q    <= 1'b0;
			end else if (!id_done_q) begin
				if (char_in == CH_SPACE) begin
					id_done_q <= 1'b1;
				end else begin
					id_q <= {id_q[ID_W-5:0], 4'h0} | {{(ID_W-8){1'b0}}, dv};
				end
			end else if (is_sep) begin
				if (last_byte) begin
					id_q         <= RESET_ID;
					ext_q        <= 1'b0;
					id_done_q    <= 1'b0;
					byte_index_q <= '0;
				end else begin
					byte_index_q <= idx_nxt;
				end
			end
		end
	end

	// payload bytes need no reset: each is cleared before it is shifted into
	always_ff @(posedge clk) begin
		if (accept && !is_start) begin
			if (!id_done_q) begin
				if (char_in == CH_SPACE) begin
					store_q[cur_idx] <= 8'h00;
				end
			end else if (is_sep) begin
				if (!last_byte) begin
					store_q[nxt_idx] <= 8'h00;
				end
			end else begin
				store_q[cur_idx] <= {store_q[cur_idx][3:0], 4'h0} | dv;
			end
		end
	end

	assign result.frame_id    = id_q;
	assign result.is_extended = ext_q;

	for (genvar k = 0; k < MAX_BYTES; k++) begin : g_out
		if (k < PAYLOAD_BYTES) begin : g_live
			assign result.data[k] = store_q[k];
		end else begin : g_zero
			assign result.data[k] = 8'h00;
		end
	end

	`AHCFP_ASSERT(a_idx_range, byte_index_q < IDX_CNT_W'(PAYLOAD_BYTES), "byte index out of range")
	`AHCFP_ASSERT(a_emit_after_id, emit |-> id_done_q, "frame emitted before id ended")
	`AHCFP_ASSERT(a_emit_clears, (accept && emit) |=> (id_q == RESET_ID && byte_index_q == '0 && !id_done_q && !ext_q), "state not cleared after frame")

endmodule
`default_nettype wire

>>> rtl/ahcfp_out_buf.sv
// Result register and skid stage; input flows during a stall until skid is full.
`default_nettype none
`include "ascii_hex_can_frame_parser_unit_defines.svh"
module ahcfp_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ahcfp_pkg::result_t push_data,
	output logic                    can_accept,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ahcfp_pkg::result_t      out_data
);
	import ahcfp_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;

	assign can_accept = !skid_v_q;
	assign out_valid  = main_v_q;
	assign out_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`AHCFP_ASSERT_ALWAYS(a_skid_needs_main, skid_v_q |-> main_v_q, "skid holds a beat while main is empty")
	`AHCFP_ASSERT(a_stall_to_skid, (main_v_q && !out_ready && push) |=> skid_v_q, "stalled beat lost")
	`AHCFP_ASSERT(a_skid_drain, (skid_v_q && out_ready) |=> (main_v_q && !skid_v_q), "skid beat not moved to main")

endmodule
`default_nettype wire
